FILE: sv/mrq_pkg.sv
// mrq_pkg: shared types and constants for the message ring queue.
// Used by mrq_cell, message_ring_queue and mrq_checker; no dependencies.
package mrq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CAP_W           = 5;
	localparam int ID_W            = 8;
	localparam int PRM_W           = 16;

	localparam logic OP_POST = 1'b0;
	localparam logic OP_PEND = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]  msg_id;
		logic [PRM_W-1:0] param;
	} entry_t;

	// per-cell controls for one cycle
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

FILE: sv/mrq_cell.sv
// mrq_cell: one storage cell of the queue chain.
// Depends on mrq_pkg for entry_t and cell_ctrl_t.
module mrq_cell (
	input  logic                clk,
	input  mrq_pkg::cell_ctrl_t ctrl,
	input  mrq_pkg::entry_t     upper,
	input  mrq_pkg::entry_t     new_entry,
	output mrq_pkg::entry_t     data
);
	import mrq_pkg::*;

	entry_t data_q;

	// payload only: no reset needed, unwritten cells are never read
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= new_entry;
		end else if (ctrl.shift) begin
			data_q <= upper;
		end
	end

	assign data = data_q;

endmodule

FILE: sv/message_ring_queue.sv
// message_ring_queue: top level of the message FIFO.
// Depends on mrq_pkg and mrq_cell; checked by mrq_checker (bound separately).
//
// A post stores {msg_id, param} unless the queue holds capacity entries; a pend
// returns the oldest entry unless the queue is empty. One transaction is taken
// every clock (busy stays low) and its result appears on the cycle after
// acceptance, marked by done for exactly one cycle, so the block runs at one
// item per clock. Entries sit in a chain of cells with the oldest in the first
// cell; a pend moves every cell's contents one place toward the head. Writing
// capacity (1..CAP_MAX, the smaller of QUEUE_DEPTH and 31; larger values
// saturate, zero is ignored) empties the queue; it resets to CAP_MAX. Results
// cannot be stalled and must be taken when shown.
module message_ring_queue #(
	parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [mrq_pkg::ID_W-1:0]  msg_id,
	input  logic [mrq_pkg::PRM_W-1:0] param,
	output logic                     done,
	output logic [1:0]               status,
	output logic [mrq_pkg::ID_W-1:0]  out_msg_id,
	output logic [mrq_pkg::PRM_W-1:0] out_param,
	output logic [mrq_pkg::CAP_W-1:0] occupancy,
	input  logic                     cfg_we,
	input  logic [mrq_pkg::CAP_W-1:0] cfg_data
);
	import mrq_pkg::*;

	localparam int CAP_LIMIT = (1 << CAP_W) - 1;
	localparam int CAP_MAX   = (QUEUE_DEPTH > CAP_LIMIT) ? CAP_LIMIT : QUEUE_DEPTH;

	logic [CAP_W-1:0] capacity_q;
	logic [CAP_W-1:0] count_q;
	logic             done_q;
	status_t          status_q;
	logic [ID_W-1:0]  out_msg_id_q;
	logic [PRM_W-1:0] out_param_q;
	logic [CAP_W-1:0] occupancy_q;

	logic    accept;
	logic    post_ok;
	logic    pend_ok;
	status_t status_d;
	entry_t  new_entry;
	entry_t  cell_data [QUEUE_DEPTH];
	logic [CAP_W-1:0] count_d;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign new_entry = '{msg_id: msg_id, param: param};

	always_comb begin
		post_ok  = 1'b0;
		pend_ok  = 1'b0;
		status_d = ST_OK;
		count_d  = count_q;
		if (opcode == OP_PEND) begin
			if (count_q != '0) begin
				pend_ok = 1'b1;
				count_d = count_q - 1'b1;
			end else begin
				status_d = ST_EMPTY;
			end
		end else begin
			if (count_q < capacity_q) begin
				post_ok = 1'b1;
				count_d = count_q + 1'b1;
			end else begin
				status_d = ST_FULL;
			end
		end
	end

	// capacity and count; a nonzero capacity write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(CAP_MAX);
			count_q    <= '0;
		end else if (cfg_we && cfg_data != '0) begin
			capacity_q <= (int'(cfg_data) > CAP_MAX) ? CAP_W'(CAP_MAX) : cfg_data;
			count_q    <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// chain of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     upper;

		assign ctrl.shift = accept && pend_ok;
		assign ctrl.load  = accept && post_ok && (int'(count_q) == i);

		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign upper = cell_data[i+1];
		end else begin : g_tail
			assign upper = cell_data[i];
		end

		mrq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.upper     (upper),
			.new_entry (new_entry),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			out_msg_id_q <= pend_ok ? cell_data[0].msg_id : '0;
			out_param_q  <= pend_ok ? cell_data[0].param : '0;
			occupancy_q  <= count_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_msg_id = out_msg_id_q;
	assign out_param  = out_param_q;
	assign occupancy  = occupancy_q;

endmodule

FILE: sv/mrq_checker.sv
// mrq_checker: port-level checks on message_ring_queue, with its bind.
// Depends on mrq_pkg for status codes and field widths.
module mrq_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     opcode,
	input logic                     done,
	input logic [1:0]               status,
	input logic [mrq_pkg::ID_W-1:0]  out_msg_id,
	input logic [mrq_pkg::PRM_W-1:0] out_param,
	input logic [mrq_pkg::CAP_W-1:0] occupancy
);
	import mrq_pkg::*;

	// every accepted transaction gives exactly one result, next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a transaction");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |->
			(occupancy == '0 && out_msg_id == '0 && out_param == '0))
		else $error("empty pend result inconsistent");

	a_post_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OK && $past(opcode) == OP_POST) |->
			(occupancy != '0 && out_msg_id == '0 && out_param == '0))
		else $error("successful post result inconsistent");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
		else $error("undefined status code");

endmodule

bind message_ring_queue mrq_checker u_mrq_checker (.*);
